/* rtl/block_bitmap_allocator_defines.svh */
// Assertion macros shared by the checker.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba: next-cycle check failed");

`endif

/* rtl/bba_pkg.sv */
package bba_pkg;

  localparam int unsigned NumBlocksDef = 64;
  localparam int unsigned BlockW       = 6;
  localparam int unsigned CountW       = 7;

  localparam logic FUNC_CONTIG  = 1'b0;
  localparam logic FUNC_SCATTER = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_USED   = 2'd1,
    ST_NOFREE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CCHK  = 6'b000100,
    S_CMARK = 6'b001000,
    S_SSCAN = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

endpackage

/* rtl/block_bitmap_allocator.sv */
// Contiguous request: the range is read, then marked, then one status beat is sent.
// Scattered request: one read of the bitmap RAM per block scanned, one beat per free block
// found; refused or zero-length requests of either kind answer with a single status beat.
// One request at a time; the bitmap RAM is scanned through its single read port.
// Reset: rst_ni clears control state, then a clearing pass frees every block; in_ready_o
// stays low until it ends.
module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [BlockW-1:0] start_block_i,
  input  logic [CountW-1:0] block_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BlockW-1:0] block_number_o,
  output logic              has_block_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);   // bitmap address
  localparam int unsigned SW = AW + 1;               // scan pointer, reaches NUM_BLOCKS
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1); // block counts

  state_e         state_q, state_d;
  logic [SW-1:0]  scan_q, scan_d;
  logic [SW-1:0]  end_q, end_d;
  logic [AW-1:0]  base_q, base_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  free_q, free_d;
  logic           seen_q, seen_d;
  logic           rd_vld_q, rd_vld_d;
  logic [AW-1:0]  rd_addr_q, rd_addr_d;
  status_e        resp_q, resp_d;

  logic              out_valid_q, out_valid_d;
  logic [BlockW-1:0] out_block_q, out_block_d;
  logic              out_has_q, out_has_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic          in_fire, can_adv, stall, issue;
  logic          sc_take, sc_final, cc_done, cc_used;
  logic [7:0]    req_end;
  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr;

  // Bitmap store: one bit per block, 1 = used.
  bba_map_ram #(
    .Depth (NUM_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // The result register can take a new beat this cycle.
  assign can_adv    = !out_valid_q || out_ready_i;
  assign req_end    = 8'(start_block_i) + 8'(block_count_i);

  // Scattered scan: a free block waiting on a full result register freezes the scan.
  assign stall    = (state_q == S_SSCAN) && rd_vld_q && !mem_rdata && !can_adv;
  assign sc_take  = (state_q == S_SSCAN) && rd_vld_q && !mem_rdata && can_adv;
  assign sc_final = sc_take && (rem_q == CW'(1));

  // Contiguous check: the last read of the range has come back.
  assign cc_used = seen_q || (rd_vld_q && mem_rdata);
  assign cc_done = (state_q == S_CCHK) && rd_vld_q
                   && ((SW'(rd_addr_q) + SW'(1)) == end_q);

  always_comb begin
    issue = 1'b0;
    unique case (state_q)
      S_CCHK:  issue = (scan_q < end_q);
      S_SSCAN: issue = !stall && !sc_final && (scan_q < SW'(NUM_BLOCKS));
      default: issue = 1'b0;
    endcase
  end

  // Write port: clearing pass, contiguous marking, scattered take.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b1;
    mem_waddr = scan_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
      end
      S_CMARK: mem_we = 1'b1;
      S_SSCAN: begin
        mem_we    = sc_take;
        mem_waddr = rd_addr_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    end_d     = end_q;
    base_d    = base_q;
    rem_d     = rem_q;
    free_d    = free_q;
    seen_d    = seen_q;
    resp_d    = resp_q;
    rd_vld_d  = issue || stall;
    rd_addr_d = issue ? scan_q[AW-1:0] : rd_addr_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_block_d  = out_block_q;
    out_has_d    = out_has_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (issue) begin
      scan_d = scan_q + SW'(1);
    end

    unique case (state_q)
      S_CLEAR: begin
        scan_d = scan_q + SW'(1);
        if (scan_q == SW'(NUM_BLOCKS - 1)) begin
          scan_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (func_i == FUNC_CONTIG) begin
            priority if (req_end > 8'(NUM_BLOCKS)) begin
              resp_d  = ST_RANGE;
              state_d = S_RESP;
            end else if (block_count_i == '0) begin
              resp_d  = ST_OK;
              state_d = S_RESP;
            end else begin
              scan_d  = SW'(start_block_i);
              base_d  = AW'(start_block_i);
              end_d   = SW'(req_end);
              rem_d   = CW'(block_count_i);
              seen_d  = 1'b0;
              state_d = S_CCHK;
            end
          end else begin
            priority if (8'(block_count_i) > 8'(free_q)) begin
              resp_d  = ST_NOFREE;
              state_d = S_RESP;
            end else if (block_count_i == '0) begin
              resp_d  = ST_OK;
              state_d = S_RESP;
            end else begin
              scan_d  = '0;
              rem_d   = CW'(block_count_i);
              state_d = S_SSCAN;
            end
          end
        end
      end
      S_CCHK: begin
        seen_d = cc_used;
        if (cc_done) begin
          if (cc_used) begin
            resp_d  = ST_USED;
            state_d = S_RESP;
          end else begin
            scan_d  = SW'(base_q);
            state_d = S_CMARK;
          end
        end
      end
      S_CMARK: begin
        scan_d = scan_q + SW'(1);
        rem_d  = rem_q - CW'(1);
        free_d = free_q - CW'(1);
        if (rem_q == CW'(1)) begin
          resp_d  = ST_OK;
          state_d = S_RESP;
        end
      end
      S_SSCAN: begin
        if (sc_take) begin
          rem_d        = rem_q - CW'(1);
          free_d       = free_q - CW'(1);
          out_valid_d  = 1'b1;
          out_block_d  = BlockW'(rd_addr_q);
          out_has_d    = 1'b1;
          out_status_d = ST_OK;
          out_last_d   = sc_final;
          if (sc_final) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (can_adv) begin
          out_valid_d  = 1'b1;
          out_block_d  = '0;
          out_has_d    = 1'b0;
          out_status_d = resp_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      scan_q      <= '0;
      end_q       <= '0;
      rem_q       <= '0;
      free_q      <= CW'(NUM_BLOCKS);
      seen_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      resp_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      end_q       <= end_d;
      rem_q       <= rem_d;
      free_q      <= free_d;
      seen_q      <= seen_d;
      rd_vld_q    <= rd_vld_d;
      resp_q      <= resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    rd_addr_q    <= rd_addr_d;
    out_block_q  <= out_block_d;
    out_has_q    <= out_has_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_block_q;
  assign has_block_o    = out_has_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

endmodule

/* rtl/bba_map_ram.sv */
module bba_map_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bba_checker.sv */
`include "block_bitmap_allocator_defines.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BlockW-1:0] block_number_o,
  input logic              has_block_o,
  input logic [1:0]        status_o,
  input logic              last_o
);

  // A named block always comes with a good status.
  `BBA_ASSERT_SAME(a_block_ok, clk_i, rst_ni, out_valid_o && has_block_o, status_o == ST_OK)

  // A beat without a block is the only answer to its request.
  `BBA_ASSERT_SAME(a_status_last, clk_i, rst_ni, out_valid_o && !has_block_o, last_o)

  // One request at a time: the input closes right after a beat is taken.
  `BBA_ASSERT_NEXT(a_one_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A stalled result holds.
  `BBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(block_number_o) && $stable(status_o)
                   && $stable(last_o) && $stable(has_block_o))

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
